// ----- hdl/bbe_pkg.sv -----
// Shared types and constants of the B-spline basis evaluator.
package bbe_pkg;

   localparam int KNOT_W  = 32;   // unsigned Q16.16
   localparam int VALUE_W = 31;   // unsigned Q1.30
   localparam int DIFF_W  = 34;   // signed knot difference / denominator

   localparam logic [VALUE_W-1:0] Q30_ONE = 31'h4000_0000;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_EVAL  = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_RANGE    = 2'd1;
   localparam logic [1:0] STATUS_ZERO_DEN = 2'd2;

   localparam logic REG_DEGREE     = 1'b0;
   localparam logic REG_KNOT_COUNT = 1'b1;

   localparam logic [1:0] DEGREE_RESET     = 2'd3;
   localparam logic [6:0] KNOT_COUNT_RESET = 7'd8;

   // request to the shared multiply/divide unit: pv * x / den
   typedef struct packed {
      logic                     start;
      logic [VALUE_W-1:0]       pv;
      logic signed [DIFF_W-1:0] x;
      logic signed [DIFF_W-1:0] den;
   } scale_req_type;

   typedef struct packed {
      logic                     done;
      logic                     busy;
      logic signed [DIFF_W-1:0] result;
   } scale_rsp_type;

endpackage

// ----- hdl/bbe_req_if.sv -----
// Input channel of the B-spline basis evaluator.
interface bbe_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [5:0]  knot_index;
   logic [31:0] knot_value;
   logic [31:0] point;

   modport source (output valid, command, knot_index, knot_value, point, input ready);
   modport sink   (input valid, command, knot_index, knot_value, point, output ready);
endinterface

// ----- hdl/bbe_rsp_if.sv -----
// Result channel of the B-spline basis evaluator.
interface bbe_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [5:0]  span;
   logic [5:0]  basis_index;
   logic [30:0] basis_value;
   logic        last;

   modport source (output valid, status, span, basis_index, basis_value, last, input ready);
   modport sink   (input valid, status, span, basis_index, basis_value, last, output ready);
endinterface

// ----- hdl/bbe_knot_ram.sv -----
// Knot table: one write port, one registered read port.
module bbe_knot_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [bbe_pkg::KNOT_W-1:0]  wr_data,
   input  logic [AW-1:0]               rd_addr,
   output logic [bbe_pkg::KNOT_W-1:0]  rd_data
);

   logic [bbe_pkg::KNOT_W-1:0] mem [DEPTH];
   logic [bbe_pkg::KNOT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/bbe_scale_unit.sv -----
// Shared unit: signed pv * x / den, magnitude truncated, quotient capped at 2^31.
module bbe_scale_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  bbe_pkg::scale_req_type  req,
   output bbe_pkg::scale_rsp_type  rsp
);

   typedef enum logic [2:0] {U_IDLE, U_MUL, U_CHK, U_DIV, U_FIN} ustate_type;

   ustate_type  state_ff, state_in;
   logic [30:0] pv_ff, pv_in;
   logic [32:0] mx_ff, mx_in;
   logic [33:0] md_ff, md_in;
   logic        neg_ff, neg_in;
   logic [63:0] prod_ff, prod_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] q_ff, q_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [34:0] trial;

   always_comb begin
      state_in = state_ff;
      pv_in    = pv_ff;
      mx_in    = mx_ff;
      md_in    = md_ff;
      neg_in   = neg_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      trial    = {rem_ff, prod_ff[30]};
      case (state_ff)
         U_MUL: begin
            prod_in  = pv_ff * mx_ff;
            state_in = U_CHK;
         end
         U_CHK: begin
            // a quotient of 2^31 or more saturates every later use
            if ({2'b00, prod_ff[62:31]} >= md_ff) begin
               q_in     = 32'h8000_0000;
               state_in = U_FIN;
            end else begin
               rem_in   = {2'b00, prod_ff[62:31]};
               q_in     = '0;
               cnt_in   = 5'd31;
               state_in = U_DIV;
            end
         end
         U_DIV: begin
            if (trial >= {1'b0, md_ff}) begin
               rem_in = 34'(trial - {1'b0, md_ff});
               q_in   = {q_ff[30:0], 1'b1};
            end else begin
               rem_in = trial[33:0];
               q_in   = {q_ff[30:0], 1'b0};
            end
            prod_in = {prod_ff[62:0], 1'b0};
            cnt_in  = cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               state_in = U_FIN;
            end
         end
         U_IDLE, U_FIN: begin
            state_in = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
      if (req.start && (state_ff == U_IDLE || state_ff == U_FIN)) begin
         pv_in    = req.pv;
         mx_in    = req.x[33] ? 33'(-req.x) : 33'(req.x);
         md_in    = req.den[33] ? 34'(-req.den) : 34'(req.den);
         neg_in   = req.x[33] ^ req.den[33];
         state_in = U_MUL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
      pv_ff   <= pv_in;
      mx_ff   <= mx_in;
      md_ff   <= md_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      cnt_ff  <= cnt_in;
   end

   assign rsp.done   = (state_ff == U_FIN);
   assign rsp.busy   = (state_ff != U_IDLE) && (state_ff != U_FIN);
   assign rsp.result = neg_ff ? -$signed({2'b00, q_ff}) : $signed({2'b00, q_ff});

endmodule

// ----- hdl/bspline_basis_evaluator_unit.sv -----
// Top level of the B-spline basis evaluator: knot table, span search, Cox-de Boor sequencer.
// An evaluation checks the point against the end knots, scans R knots for the span (one knot
//   table read per cycle) and then runs D*(D+1)/2 recurrence steps, D being the degree, unless
//   the point is on the first knot of the valid range; each recurrence step runs two
//   multiply/divide passes in the shared unit. The block takes one item at a time, and an
//   evaluation hands out D+1 words. Error results skip the remaining steps and leave as one word.
// Reset (synchronous, active high) clears the sequencer and output valid and sets degree 3 and
//   knot count 8; the knot table is not cleared and must be written before use.
module bspline_basis_evaluator_unit #(
   parameter int MAX_DEGREE = 3,
   parameter int MAX_KNOTS  = 64
) (
   input  logic        clock,
   input  logic        reset,
   bbe_req_if.sink     req_ch,
   bbe_rsp_if.source   rsp_ch,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int AW = $clog2(MAX_KNOTS);          // knot table address
   localparam int CW = $clog2(MAX_KNOTS + 1);      // knot count / scan position
   localparam int NW = (CW > 7) ? CW : 7;
   localparam int PW = $clog2(MAX_DEGREE + 1);     // degree and recurrence counters
   localparam int VW = bbe_pkg::VALUE_W;
   localparam int DW = bbe_pkg::DIFF_W;

   typedef enum logic [3:0] {
      S_IDLE, S_CHK0, S_CHKN, S_SCAN, S_LEFT, S_LJ, S_RJ, S_DEN, S_M1, S_M2, S_EMIT
   } state_type;

   // configuration
   logic [1:0] degree_ff, degree_in;
   logic [6:0] knot_count_ff, knot_count_in;
   logic [PW-1:0] p_eff;
   logic [CW-1:0] n_eff;

   // sequencer
   state_type state_ff, state_in;
   logic [31:0]   t_ff, t_in;
   logic [PW-1:0] p_ff, p_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] ret_ff, ret_in;
   logic [AW-1:0] span_ff, span_in;
   logic [PW-1:0] j_ff, j_in, r_ff, r_in, k_ff, k_in;
   logic [VW-1:0] saved_ff, saved_in;
   logic [VW-1:0] pv_ff, pv_in;
   logic signed [DW-1:0] den_ff, den_in;
   logic [1:0]    err_ff, err_in;
   logic [VW-1:0] pb_ff [MAX_DEGREE+1];
   logic [VW-1:0] pb_in [MAX_DEGREE+1];
   logic signed [DW-1:0] left_ff [MAX_DEGREE+1];
   logic signed [DW-1:0] left_in [MAX_DEGREE+1];
   logic signed [DW-1:0] right_ff [MAX_DEGREE+1];
   logic signed [DW-1:0] right_in [MAX_DEGREE+1];

   // output register
   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_status_ff, out_status_in;
   logic [5:0]  out_span_ff, out_span_in;
   logic [5:0]  out_index_ff, out_index_in;
   logic [VW-1:0] out_value_ff, out_value_in;
   logic        out_last_ff, out_last_in;

   // knot table and shared unit
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic [31:0]   rd_data;
   bbe_pkg::scale_req_type scale_req;
   bbe_pkg::scale_rsp_type scale_rsp;

   // helpers
   logic          req_accept;
   logic          cfg_write;
   logic [PW-1:0] idx_r1, idx_jr;
   logic          scan_done;
   logic [CW-1:0] ret_sel, ret_next, lim, spn_c;
   logic signed [DW-1:0] den_c;
   logic [VW-1:0] sv_c;
   logic [AW-1:0] emit_index;

   function automatic logic [VW-1:0] clamp_q30(input logic signed [DW:0] v);
      logic [VW-1:0] res;
      if (v < 0) begin
         res = '0;
      end else if (v > $signed({4'b0000, bbe_pkg::Q30_ONE})) begin
         res = bbe_pkg::Q30_ONE;
      end else begin
         res = v[VW-1:0];
      end
      return res;
   endfunction

   bbe_knot_ram #(.DEPTH(MAX_KNOTS), .AW(AW)) u_knot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_ch.knot_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bbe_scale_unit u_scale_unit (
      .clock (clock),
      .reset (reset),
      .req   (scale_req),
      .rsp   (scale_rsp)
   );

   // effective degree and knot count, capped at the build limits
   assign p_eff = ({1'b0, degree_ff} > 3'(MAX_DEGREE)) ? PW'(MAX_DEGREE) : PW'(degree_ff);
   assign n_eff = (NW'(knot_count_ff) > NW'(MAX_KNOTS)) ? CW'(MAX_KNOTS) : CW'(knot_count_ff);

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign cfg_write    = psel && penable && pwrite && pready;
   assign pready       = 1'b1;
   assign prdata = (paddr[2] == bbe_pkg::REG_KNOT_COUNT) ? {25'b0, knot_count_ff}
                                                         : {30'b0, degree_ff};

   assign idx_r1 = r_ff + PW'(1);
   assign idx_jr = j_ff - r_ff;
   assign den_c  = right_ff[idx_r1] + left_ff[idx_jr];
   assign sv_c   = clamp_q30({scale_rsp.result[DW-1], scale_rsp.result});
   assign emit_index = span_ff - AW'(p_ff) + AW'(k_ff);

   // span search: the scan stops at the first knot above the point or at the last knot in use
   assign ret_next  = ret_ff + CW'(1);
   assign scan_done = (rd_data > t_ff) || (ret_next == n_ff);
   assign ret_sel   = (rd_data > t_ff) ? ret_ff : ret_next;
   assign lim       = n_ff - CW'(p_ff) - CW'(2);
   assign spn_c     = ((ret_sel - CW'(1)) > lim) ? lim : (ret_sel - CW'(1));

   always_comb begin
      state_in      = state_ff;
      degree_in     = degree_ff;
      knot_count_in = knot_count_ff;
      t_in     = t_ff;
      p_in     = p_ff;
      n_in     = n_ff;
      ret_in   = ret_ff;
      span_in  = span_ff;
      j_in     = j_ff;
      r_in     = r_ff;
      k_in     = k_ff;
      saved_in = saved_ff;
      pv_in    = pv_ff;
      den_in   = den_ff;
      err_in   = err_ff;
      pb_in    = pb_ff;
      left_in  = left_ff;
      right_in = right_ff;
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_span_in   = out_span_ff;
      out_index_in  = out_index_ff;
      out_value_in  = out_value_ff;
      out_last_in   = out_last_ff;
      wr_en   = 1'b0;
      wr_addr = AW'(req_ch.knot_index);
      rd_addr = '0;
      scale_req.start = 1'b0;
      scale_req.pv    = pv_ff;
      scale_req.x     = left_ff[idx_jr];
      scale_req.den   = den_ff;

      if (cfg_write) begin
         if (paddr[2] == bbe_pkg::REG_DEGREE) begin
            degree_in = pwdata[1:0];
         end else begin
            knot_count_in = pwdata[6:0];
         end
      end

      // drop the word once the sink takes it
      if (out_valid_ff && rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_ch.command == bbe_pkg::CMD_WRITE) begin
                  wr_en = (int'(req_ch.knot_index) < MAX_KNOTS);
               end else begin
                  t_in   = req_ch.point;
                  p_in   = p_eff;
                  n_in   = n_eff;
                  err_in = bbe_pkg::STATUS_OK;
                  if (int'(n_eff) < int'(p_eff) + 2) begin
                     err_in   = bbe_pkg::STATUS_RANGE;
                     state_in = S_EMIT;
                  end else begin
                     rd_addr  = '0;
                     state_in = S_CHK0;
                  end
               end
            end
         end
         S_CHK0: begin
            if (t_ff < rd_data) begin
               err_in   = bbe_pkg::STATUS_RANGE;
               state_in = S_EMIT;
            end else begin
               rd_addr  = AW'(n_ff - CW'(1));
               state_in = S_CHKN;
            end
         end
         S_CHKN: begin
            if (t_ff > rd_data) begin
               err_in   = bbe_pkg::STATUS_RANGE;
               state_in = S_EMIT;
            end else begin
               ret_in   = '0;
               rd_addr  = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               // a span below the degree lacks a full set of supporting knots
               if (spn_c < CW'(p_ff)) begin
                  err_in   = bbe_pkg::STATUS_RANGE;
                  state_in = S_EMIT;
               end else begin
                  span_in  = AW'(spn_c);
                  rd_addr  = AW'(spn_c);
                  state_in = S_LEFT;
               end
            end else begin
               ret_in  = ret_next;
               rd_addr = AW'(ret_next);
            end
         end
         S_LEFT: begin
            for (int i = 0; i <= MAX_DEGREE; i++) begin
               pb_in[i] = bbe_pkg::Q30_ONE;
            end
            k_in = '0;
            if (p_ff == '0) begin
               state_in = S_EMIT;
            end else if ((int'(span_ff) == int'(p_ff)) && (t_ff == rd_data)) begin
               // point on the first knot of the valid range: first basis is exactly one
               for (int i = 1; i <= MAX_DEGREE; i++) begin
                  pb_in[i] = '0;
               end
               state_in = S_EMIT;
            end else begin
               j_in     = PW'(1);
               rd_addr  = span_ff;
               state_in = S_LJ;
            end
         end
         S_LJ: begin
            left_in[j_ff] = $signed({2'b00, t_ff}) - $signed({2'b00, rd_data});
            rd_addr  = span_ff + AW'(j_ff);
            state_in = S_RJ;
         end
         S_RJ: begin
            right_in[j_ff] = $signed({2'b00, rd_data}) - $signed({2'b00, t_ff});
            r_in     = '0;
            saved_in = '0;
            state_in = S_DEN;
         end
         S_DEN: begin
            if (den_c == '0) begin
               err_in   = bbe_pkg::STATUS_ZERO_DEN;
               state_in = S_EMIT;
            end else begin
               scale_req.start = 1'b1;
               scale_req.pv    = pb_ff[r_ff];
               scale_req.x     = right_ff[idx_r1];
               scale_req.den   = den_c;
               pv_in    = pb_ff[r_ff];
               den_in   = den_c;
               state_in = S_M1;
            end
         end
         S_M1: begin
            if (scale_rsp.done) begin
               pb_in[r_ff] = clamp_q30($signed({4'b0000, saved_ff}) +
                                       {scale_rsp.result[DW-1], scale_rsp.result});
               scale_req.start = 1'b1;
               state_in = S_M2;
            end
         end
         S_M2: begin
            if (scale_rsp.done) begin
               saved_in = sv_c;
               if (idx_r1 < j_ff) begin
                  r_in     = idx_r1;
                  state_in = S_DEN;
               end else begin
                  pb_in[j_ff] = sv_c;
                  if (j_ff == p_ff) begin
                     k_in     = '0;
                     state_in = S_EMIT;
                  end else begin
                     j_in     = j_ff + PW'(1);
                     rd_addr  = span_ff - AW'(j_ff);
                     state_in = S_LJ;
                  end
               end
            end
         end
         S_EMIT: begin
            // hold until the output register is free
            if (!out_valid_ff || rsp_ch.ready) begin
               out_valid_in = 1'b1;
               if (err_ff != bbe_pkg::STATUS_OK) begin
                  out_status_in = err_ff;
                  out_span_in   = (err_ff == bbe_pkg::STATUS_ZERO_DEN) ? 6'(span_ff) : 6'd0;
                  out_index_in  = 6'd0;
                  out_value_in  = '0;
                  out_last_in   = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  out_status_in = bbe_pkg::STATUS_OK;
                  out_span_in   = 6'(span_ff);
                  out_index_in  = 6'(emit_index);
                  out_value_in  = pb_ff[k_ff];
                  out_last_in   = (k_ff == p_ff);
                  if (k_ff == p_ff) begin
                     state_in = S_IDLE;
                  end else begin
                     k_in = k_ff + PW'(1);
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         out_valid_ff  <= 1'b0;
         degree_ff     <= bbe_pkg::DEGREE_RESET;
         knot_count_ff <= bbe_pkg::KNOT_COUNT_RESET;
      end else begin
         state_ff      <= state_in;
         out_valid_ff  <= out_valid_in;
         degree_ff     <= degree_in;
         knot_count_ff <= knot_count_in;
      end
      t_ff     <= t_in;
      p_ff     <= p_in;
      n_ff     <= n_in;
      ret_ff   <= ret_in;
      span_ff  <= span_in;
      j_ff     <= j_in;
      r_ff     <= r_in;
      k_ff     <= k_in;
      saved_ff <= saved_in;
      pv_ff    <= pv_in;
      den_ff   <= den_in;
      err_ff   <= err_in;
      pb_ff    <= pb_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      out_status_ff <= out_status_in;
      out_span_ff   <= out_span_in;
      out_index_ff  <= out_index_in;
      out_value_ff  <= out_value_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.status      = out_status_ff;
   assign rsp_ch.span        = out_span_ff;
   assign rsp_ch.basis_index = out_index_ff;
   assign rsp_ch.basis_value = out_value_ff;
   assign rsp_ch.last        = out_last_ff;

   // the shared unit is only started when it has no pass in flight
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      scale_req.start |-> !scale_rsp.busy)
      else $error("shared unit started while busy");

   // an error word is always the only word of its evaluation
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status != bbe_pkg::STATUS_OK) |-> rsp_ch.last)
      else $error("error word not marked last");

   // basis values never exceed one
   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.basis_value <= bbe_pkg::Q30_ONE))
      else $error("basis value above one");

   // ready is low in the cycle after an evaluation is accepted
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_ch.command == bbe_pkg::CMD_EVAL) |=> !req_ch.ready)
      else $error("ready during evaluation");

endmodule

// ----- tb/bspline_basis_evaluator_unit_tb.sv -----
// Self-checking testbench of the B-spline basis evaluator: directed table, then random phases.
`timescale 1ns / 100ps

module bspline_basis_evaluator_unit_tb;

   localparam int MAX_DEG = 3;
   localparam int MAX_KN  = 64;
   localparam int PHASES  = 9;

   typedef struct {
      logic [1:0]  status;
      logic [5:0]  span;
      logic [5:0]  basis_index;
      logic [30:0] basis_value;
      logic        last;
   } basis_word_type;

   typedef struct {
      logic        command;
      logic [5:0]  knot_index;
      logic [31:0] knot_value;
      logic [31:0] point;
      bit          typed;      // expectation typed in below, predictor not used
      logic [1:0]  exp_status;
      logic [5:0]  exp_span;
   } stim_row_type;

   logic clock;
   logic reset;
   logic psel, penable, pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   bbe_req_if req ();
   bbe_rsp_if rsp ();

   bspline_basis_evaluator_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req),
      .rsp_ch  (rsp),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Shadow of the block: configuration and knot table as the block should hold them.
   logic [1:0]  shadow_degree;
   logic [6:0]  shadow_knot_count;
   logic [31:0] shadow_knots [MAX_KN];

   basis_word_type expected_words [$];
   int          mismatch_count;
   bit          steady_mode;       // no random idling on either side while set
   bit          long_hold_pending; // ask the receiver for one long hold-off
   bit          req_held;          // valid left high after the last accepted word

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Limit: end the run if it hangs.
   initial begin
      #30ms;
      $display("FAILURE");
      $finish;
   end

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   function automatic void push_word(input logic [1:0] st, input longint sp, input longint bi,
                                     input longint bv, input bit last_word);
      basis_word_type w;
      w.status      = st;
      w.span        = sp[5:0];
      w.basis_index = bi[5:0];
      w.basis_value = bv[30:0];
      w.last        = last_word;
      expected_words.push_back(w);
   endfunction

   function automatic longint knot_at(input longint i);
      return longint'({32'b0, shadow_knots[i]});
   endfunction

   function automatic longint sat_q30(input longint v);
      if (v < 0) return 0;
      if (v > longint'(bbe_pkg::Q30_ONE)) return longint'(bbe_pkg::Q30_ONE);
      return v;
   endfunction

   // pv * x / den, magnitude truncated toward zero
   function automatic longint mul_div(input longint pv, input longint x, input longint den);
      longint unsigned mx, md, q;
      mx = (x < 0) ? -x : x;
      md = (den < 0) ? -den : den;
      q  = (longint'(pv) * mx) / md;
      return ((x < 0) != (den < 0)) ? -longint'(q) : longint'(q);
   endfunction

   // Span search plus Cox-de Boor recurrence; queue the words of one evaluation.
   function automatic void predict_basis(input logic [31:0] point_in);
      longint p, n, t, ret, span, saved, den, pv;
      longint vals [MAX_DEG+1];
      longint lft  [MAX_DEG+1];
      longint rgt  [MAX_DEG+1];
      p = shadow_degree;
      if (p > MAX_DEG) p = MAX_DEG;
      n = shadow_knot_count;
      if (n > MAX_KN) n = MAX_KN;
      t = longint'({32'b0, point_in});
      if (n < p + 2) begin
         push_word(bbe_pkg::STATUS_RANGE, 0, 0, 0, 1);
         return;
      end
      if (t < knot_at(0) || t > knot_at(n - 1)) begin
         push_word(bbe_pkg::STATUS_RANGE, 0, 0, 0, 1);
         return;
      end
      ret = 0;
      while (ret < n && knot_at(ret) <= t) ret++;
      span = (ret > n - p - 2) ? n - p - 2 : ret - 1;
      if (span < p) begin
         push_word(bbe_pkg::STATUS_RANGE, 0, 0, 0, 1);
         return;
      end
      for (int k = 0; k <= p; k++) vals[k] = longint'(bbe_pkg::Q30_ONE);
      if (span == p && t == knot_at(span)) begin
         // left end: first value exactly one
         for (int k = 1; k <= p; k++) vals[k] = 0;
      end else begin
         lft[0] = 0;
         rgt[0] = 0;
         for (int j = 1; j <= p; j++) begin
            saved  = 0;
            lft[j] = t - knot_at(span + 1 - j);
            rgt[j] = knot_at(span + j) - t;
            for (int r = 0; r < j; r++) begin
               den = rgt[r+1] + lft[j-r];
               if (den == 0) begin
                  push_word(bbe_pkg::STATUS_ZERO_DEN, span, 0, 0, 1);
                  return;
               end
               pv      = vals[r];
               vals[r] = sat_q30(saved + mul_div(pv, rgt[r+1], den));
               saved   = sat_q30(mul_div(pv, lft[j-r], den));
            end
            vals[j] = saved;
         end
      end
      for (int k = 0; k <= p; k++)
         push_word(bbe_pkg::STATUS_OK, span, span - p + k, vals[k], k == p);
   endfunction

   // Write one register through the APB port; update the shadow at the access edge.
   task automatic csr_write(input logic reg_index, input logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (reg_index == bbe_pkg::REG_DEGREE) shadow_degree = value[1:0];
      else shadow_knot_count = value[6:0];
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Hold the sender until every expected word is back, then let the block settle.
   task automatic wait_idle();
      while (expected_words.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   // Drop valid after the last word of a burst unless a gap already dropped it.
   task automatic release_req();
      if (req_held) req.valid <= 1'b0;
      req_held = 1'b0;
   endtask

   // Offer one word and hold it until accepted; predict at the accepting edge.
   task automatic send_word(input stim_row_type row);
      int gap;
      int roll;
      req.valid      <= 1'b1;
      req.command    <= row.command;
      req.knot_index <= row.knot_index;
      req.knot_value <= row.knot_value;
      req.point      <= row.point;
      do @(posedge clock); while (!req.ready);
      if (row.command == bbe_pkg::CMD_WRITE) begin
         shadow_knots[row.knot_index] = row.knot_value;
      end else if (row.typed) begin
         push_word(row.exp_status, row.exp_span, 0, 0, 1);
      end else begin
         predict_basis(row.point);
      end
      // drop valid only when a gap follows, otherwise the next word overwrites it
      gap = 0;
      if (!steady_mode) begin
         roll = $urandom_range(0, 99);
         if (roll < 60) gap = 0;
         else if (roll < 95) gap = $urandom_range(1, 3);
         else gap = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         req.valid <= 1'b0;
         req_held = 1'b0;
         repeat (gap) @(posedge clock);
      end else begin
         req_held = 1'b1;
      end
   endtask

   function automatic stim_row_type knot_row(input int idx, input logic [31:0] value);
      stim_row_type row;
      row = '{default: '0};
      row.command    = bbe_pkg::CMD_WRITE;
      row.knot_index = idx[5:0];
      row.knot_value = value;
      row.point      = $urandom;
      return row;
   endfunction

   function automatic stim_row_type eval_row(input logic [31:0] pt);
      stim_row_type row;
      row = '{default: '0};
      row.command    = bbe_pkg::CMD_EVAL;
      row.knot_index = $urandom;
      row.knot_value = $urandom;
      row.point      = pt;
      return row;
   endfunction

   function automatic stim_row_type typed_row(input logic [31:0] pt, input logic [1:0] st,
                                              input logic [5:0] sp);
      stim_row_type row;
      row = eval_row(pt);
      row.typed      = 1'b1;
      row.exp_status = st;
      row.exp_span   = sp;
      return row;
   endfunction

   // Pick an evaluation point: mostly inside the knots in use, sometimes on a knot or outside.
   function automatic logic [31:0] pick_point();
      longint lo, hi, n;
      int sel;
      n   = shadow_knot_count;
      lo  = knot_at(0);
      hi  = knot_at(n - 1);
      sel = $urandom_range(0, 9);
      if (sel <= 5) begin
         if (hi > lo) return 32'(lo + longint'($urandom) % (hi - lo + 1));
         return 32'(lo);
      end else if (sel <= 7) begin
         return shadow_knots[$urandom_range(0, n - 1)];
      end else if (sel == 8) begin
         return $urandom;
      end
      if ($urandom_range(0, 1) && lo > 0) return 32'(lo - 1);
      return (hi < 64'hFFFF_FFFF) ? 32'(hi + 1) : 32'hFFFF_FFFF;
   endfunction

   // Receiver: check every accepted word and stall at random.
   initial begin
      int stall_left;
      int roll;
      basis_word_type w;
      stall_left = 0;
      rsp.ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready) begin
            if (expected_words.size() == 0) begin
               report($sformatf("unexpected word status %0d span %0d index %0d value %h",
                                rsp.status, rsp.span, rsp.basis_index, rsp.basis_value));
            end else begin
               w = expected_words.pop_front();
               if (rsp.status !== w.status)
                  report($sformatf("status %0d, want %0d", rsp.status, w.status));
               if (rsp.span !== w.span)
                  report($sformatf("span %0d, want %0d", rsp.span, w.span));
               if (rsp.basis_index !== w.basis_index)
                  report($sformatf("basis_index %0d, want %0d", rsp.basis_index, w.basis_index));
               if (rsp.basis_value !== w.basis_value)
                  report($sformatf("basis_value %h, want %h", rsp.basis_value, w.basis_value));
               if (rsp.last !== w.last)
                  report($sformatf("last %0d, want %0d", rsp.last, w.last));
            end
         end
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            stall_left = 2500;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp.ready <= 1'b0;
         end else if (steady_mode) begin
            rsp.ready <= 1'b1;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
               rsp.ready <= 1'b1;
            end else if (roll < 97) begin
               stall_left = $urandom_range(1, 4);
               rsp.ready <= 1'b0;
            end else begin
               stall_left = $urandom_range(20, 60);
               rsp.ready <= 1'b0;
            end
         end
      end
   end

   // Sender: reset, directed table, then random phases.
   initial begin
      stim_row_type directed [$];
      stim_row_type row;
      int phase_degree [PHASES] = '{0, 3, 1, 2, 3, 0, 3, 2, 3};
      int phase_count  [PHASES] = '{2, 64, 5, 17, 3, 64, 12, 9, 8};
      longint knot_acc;
      int evals;

      reset          = 1'b1;
      req.valid      = 1'b0;
      req.command    = bbe_pkg::CMD_WRITE;
      req.knot_index = '0;
      req.knot_value = '0;
      req.point      = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      mismatch_count    = 0;
      steady_mode       = 1'b0;
      long_hold_pending = 1'b0;
      req_held          = 1'b0;
      shadow_degree     = bbe_pkg::DEGREE_RESET;
      shadow_knot_count = bbe_pkg::KNOT_COUNT_RESET;
      foreach (shadow_knots[i]) shadow_knots[i] = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Clamped cubic on [0, 1] with the reset configuration.
      for (int i = 0; i < 4; i++) directed.push_back(knot_row(i, 32'h0));
      for (int i = 4; i < 8; i++) directed.push_back(knot_row(i, 32'h0001_0000));
      directed.push_back(eval_row(32'h0));            // left end: first value exactly one
      directed.push_back(eval_row(32'h0000_8000));
      directed.push_back(eval_row(32'h0000_4000));
      directed.push_back(eval_row(32'h0001_0000));    // right end, span capped
      directed.push_back(typed_row(32'h0001_0001, bbe_pkg::STATUS_RANGE, 6'd0));
      directed.push_back(typed_row(32'hFFFF_FFFF, bbe_pkg::STATUS_RANGE, 6'd0));
      // Repeated knot under the capped span: zero denominator.
      directed.push_back(knot_row(4, 32'h0));
      directed.push_back(typed_row(32'h0000_8000, bbe_pkg::STATUS_ZERO_DEN, 6'd3));
      directed.push_back(eval_row(32'h0));
      // First knot above the point: below range.
      directed.push_back(knot_row(0, 32'hFFFF_FFFF));
      directed.push_back(typed_row(32'h0, bbe_pkg::STATUS_RANGE, 6'd0));
      directed.push_back(knot_row(0, 32'h0));
      directed.push_back(eval_row(32'h0000_C000));
      foreach (directed[i]) send_word(directed[i]);
      release_req();

      for (int ph = 0; ph < PHASES; ph++) begin
         wait_idle();
         steady_mode = (ph % 4 == 1);
         csr_write(bbe_pkg::REG_DEGREE, 32'(phase_degree[ph]));
         csr_write(bbe_pkg::REG_KNOT_COUNT, 32'(phase_count[ph]));
         // Nondecreasing table with repeats; some phases start high in the range.
         knot_acc = ($urandom_range(0, 3) == 0) ? longint'($urandom) : $urandom_range(0, 4);
         for (int i = 0; i < phase_count[ph]; i++) begin
            if (knot_acc > 64'hFFFF_FFFF) knot_acc = 64'hFFFF_FFFF;
            send_word(knot_row(i, 32'(knot_acc)));
            if ($urandom_range(0, 4) != 0) knot_acc += $urandom_range(1, 32'h0003_0000);
         end
         if (ph == 1) long_hold_pending = 1'b1;
         evals = (phase_count[ph] == 64) ? 12 : 17;
         for (int e = 0; e < evals; e++) begin
            if ($urandom_range(0, 9) == 0) begin
               // noise: overwrite any entry with any value
               row = knot_row($urandom_range(0, MAX_KN - 1), $urandom);
               send_word(row);
            end
            send_word(eval_row(pick_point()));
         end
         release_req();
      end

      while (expected_words.size() != 0) @(posedge clock);
      repeat (600) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
